/* rtl/pee_pkg.sv */
// Shared types and constants for the prefix expression evaluator.
`default_nettype none
package pee_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_BADOP     = 3'd4;
  localparam logic [2:0] ST_BADDEPTH  = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_DIV,
    S_FIN,
    S_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       in_load;
    logic       push;
    logic       err_set;
    logic [2:0] err_code;
    logic       rd_top;
    logic       rd_next;
    logic       cap_left;
    logic       cap_right;
    logic       alu_wb;
    logic       div_start;
    logic       div_wb;
    logic       fin_load;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic err_pend;
    logic is_digit;
    logic is_space;
    logic full;
    logic lt2;
    logic op_add;
    logic op_sub;
    logic op_mul;
    logic op_div;
    logic right_zero;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/prefix_expression_evaluator.sv */
// Top level of the prefix expression evaluator: controller, datapath and checks.
//
// Feed an expression one ASCII character per input beat, last character first,
// with last set on the final character. Digits push, a space is skipped, and
// + - * / pop two operands (first popped is the left operand) and push the result.
// One output beat follows each beat marked last: value and status
// (0 ok, 1 overflow, 2 underflow, 3 divide by zero, 4 bad operator, 5 bad depth).
// The first error sticks until the expression ends.
// States per input beat, from idle, following the controller sequence and the stack RAM port:
//   digit, space, operator on a short stack or error pending: idle, decode, finish;
//   other characters: idle, decode, read top, read next, execute, then for / a divide
//   (32-step radix-2 divider, skipped on a zero divisor), finish. A beat marked last
//   adds load and emit; the output beat is presented in the cycle the input reopens.
// in_stall is high from the accept until the character is fully processed.
// A finished result waits in the output register while the next expression
// enters; if the register is still occupied at emit time, the block holds.
// Reset (rst, synchronous) empties the stack and clears the error and output valid.
`default_nettype none
module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pee_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pee_pkg::out_t      out_data
);

  pee_pkg::cmd_t cmd;
  pee_pkg::sts_t sts;

  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous beat still in flight");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.alu_wb, cmd.div_wb}))
    else $error("more than one stack write in a cycle");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("result emitted over a stalled beat");

endmodule
`default_nettype wire

/* rtl/pee_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module pee_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;

endmodule
`default_nettype wire

/* rtl/pee_ctrl.sv */
// Controller state machine: sequences decode, stack reads, execute, divide and result emit.
`default_nettype none
module pee_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire pee_pkg::sts_t sts,
  output logic               in_stall,
  output pee_pkg::cmd_t      cmd
);

  pee_pkg::state_t state;
  pee_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pee_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pee_pkg::S_IDLE: begin
        if (in_valid) state_next = pee_pkg::S_DECODE;
      end
      pee_pkg::S_DECODE: begin
        if (sts.err_pend || sts.is_digit || sts.is_space || sts.lt2) begin
          state_next = pee_pkg::S_FIN;
        end else begin
          state_next = pee_pkg::S_RD1;
        end
      end
      pee_pkg::S_RD1: state_next = pee_pkg::S_RD2;
      pee_pkg::S_RD2: state_next = pee_pkg::S_EXEC;
      pee_pkg::S_EXEC: begin
        if (sts.op_div && !sts.right_zero) begin
          state_next = pee_pkg::S_DIV;
        end else begin
          state_next = pee_pkg::S_FIN;
        end
      end
      pee_pkg::S_DIV: begin
        if (sts.div_done) state_next = pee_pkg::S_FIN;
      end
      pee_pkg::S_FIN: begin
        state_next = sts.last ? pee_pkg::S_LOAD : pee_pkg::S_IDLE;
      end
      pee_pkg::S_LOAD: state_next = pee_pkg::S_EMIT;
      pee_pkg::S_EMIT: begin
        if (!sts.out_busy) state_next = pee_pkg::S_IDLE;
      end
      default: state_next = pee_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != pee_pkg::S_IDLE);
    unique case (state)
      pee_pkg::S_IDLE: cmd.in_load = in_valid;
      pee_pkg::S_DECODE: begin
        if (!sts.err_pend) begin
          if (sts.is_digit) begin
            if (sts.full) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = pee_pkg::ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (!sts.is_space) begin
            if (sts.lt2) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = pee_pkg::ST_UNDERFLOW;
            end else begin
              cmd.rd_top = 1'b1;
            end
          end
        end
      end
      pee_pkg::S_RD1: begin
        cmd.cap_left = 1'b1;
        cmd.rd_next  = 1'b1;
      end
      pee_pkg::S_RD2: cmd.cap_right = 1'b1;
      pee_pkg::S_EXEC: begin
        if (sts.op_add || sts.op_sub || sts.op_mul) begin
          cmd.alu_wb = 1'b1;
        end else if (sts.op_div) begin
          if (sts.right_zero) begin
            cmd.err_set  = 1'b1;
            cmd.err_code = pee_pkg::ST_DIVZERO;
          end else begin
            cmd.div_start = 1'b1;
          end
        end else begin
          cmd.err_set  = 1'b1;
          cmd.err_code = pee_pkg::ST_BADOP;
        end
      end
      pee_pkg::S_DIV: cmd.div_wb = sts.div_done;
      pee_pkg::S_FIN: ;
      pee_pkg::S_LOAD: cmd.fin_load = 1'b1;
      pee_pkg::S_EMIT: cmd.emit = !sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/pee_dp.sv */
// Datapath: operand stack memory, ALU, divider, error register and output register.
`default_nettype none
module pee_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pee_pkg::in_t  in_data,
  input  wire pee_pkg::cmd_t cmd,
  input  wire logic          out_stall,
  output pee_pkg::sts_t      sts,
  output logic               out_valid,
  output pee_pkg::out_t      out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [CW-1:0] count;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [2:0]    err;
  pee_pkg::in_t  cur;
  logic [31:0]   left;
  logic [31:0]   right;
  logic [31:0]   alu_res;
  logic [31:0]   fval;
  logic [2:0]    fstat;
  logic          div_done;
  logic [31:0]   div_q;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  pee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (left),
    .divisor  (right),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (cmd.rd_next) begin
      raddr = cnt_m2[AW-1:0];
    end else if (cmd.rd_top) begin
      raddr = cnt_m1[AW-1:0];
    end else begin
      raddr = '0;
    end
  end

  always_comb begin
    case (cur.ch)
      pee_pkg::CH_ADD: alu_res = left + right;
      pee_pkg::CH_SUB: alu_res = left - right;
      default:         alu_res = left * right;
    endcase
  end

  assign mem_we = cmd.push || cmd.alu_wb || cmd.div_wb;
  assign waddr  = cmd.push ? count[AW-1:0] : cnt_m2[AW-1:0];
  always_comb begin
    if (cmd.push) begin
      wdata = {28'd0, cur.ch[3:0]};
    end else if (cmd.div_wb) begin
      wdata = div_q;
    end else begin
      wdata = alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= pee_pkg::ST_OK;
    end else begin
      if (cmd.emit) begin
        count <= '0;
        err   <= pee_pkg::ST_OK;
      end else begin
        if (cmd.push) count <= count + CW'(1);
        if (cmd.alu_wb || cmd.div_wb) count <= cnt_m1;
        if (cmd.err_set) err <= cmd.err_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) cur <= in_data;
    if (cmd.cap_left) left <= rdata;
    if (cmd.cap_right) right <= rdata;
    if (cmd.fin_load) begin
      if (err != pee_pkg::ST_OK) begin
        fstat <= err;
        fval  <= '0;
      end else if (count != CW'(1)) begin
        fstat <= pee_pkg::ST_BADDEPTH;
        fval  <= '0;
      end else begin
        fstat <= pee_pkg::ST_OK;
        fval  <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.value  <= fval;
      out_data.status <= fstat;
    end
  end

  always_comb begin
    sts.last       = cur.last;
    sts.err_pend   = (err != pee_pkg::ST_OK);
    sts.is_digit   = (cur.ch >= pee_pkg::CH_ZERO) && (cur.ch <= pee_pkg::CH_NINE);
    sts.is_space   = (cur.ch == pee_pkg::CH_SPACE);
    sts.full       = (count >= CW'(STACK_DEPTH));
    sts.lt2        = (count < CW'(2));
    sts.op_add     = (cur.ch == pee_pkg::CH_ADD);
    sts.op_sub     = (cur.ch == pee_pkg::CH_SUB);
    sts.op_mul     = (cur.ch == pee_pkg::CH_MUL);
    sts.op_div     = (cur.ch == pee_pkg::CH_DIV);
    sts.right_zero = (right == 32'd0);
    sts.div_done   = div_done;
    sts.out_busy   = out_valid && out_stall;
  end

endmodule
`default_nettype wire

/* tb/tb_prefix_expression_evaluator.sv */
// Self-checking testbench for the prefix expression evaluator: random and directed expressions.
`default_nettype none
module tb_prefix_expression_evaluator;

  localparam int DEPTH = 64;
  localparam int PHASE_BEATS = 420;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int QUIET_LIMIT = 6000;
  localparam logic [7:0] OP_CHARS [4] = '{pee_pkg::CH_ADD, pee_pkg::CH_SUB,
                                          pee_pkg::CH_MUL, pee_pkg::CH_DIV};

  class expr_scoreboard;
    logic [31:0] operands [DEPTH];
    int unsigned depth;
    logic [2:0] err = pee_pkg::ST_OK;
    pee_pkg::out_t expected_q[$];
    int errors;
    int checked;
    int status_seen [8];

    function void note_input(pee_pkg::in_t beat);
      logic [31:0] lhs, rhs, res, mag_l, mag_r, quo;
      pee_pkg::out_t r;
      if (err == pee_pkg::ST_OK) begin
        if (beat.ch >= pee_pkg::CH_ZERO && beat.ch <= pee_pkg::CH_NINE) begin
          if (depth >= DEPTH) begin
            err = pee_pkg::ST_OVERFLOW;
          end else begin
            operands[depth] = 32'(beat.ch - pee_pkg::CH_ZERO);
            depth++;
          end
        end else if (beat.ch != pee_pkg::CH_SPACE) begin
          if (depth < 2) begin
            err = pee_pkg::ST_UNDERFLOW;
          end else begin
            lhs = operands[depth - 1];
            rhs = operands[depth - 2];
            depth -= 2;
            res = '0;
            case (beat.ch)
              pee_pkg::CH_ADD: res = lhs + rhs;
              pee_pkg::CH_SUB: res = lhs - rhs;
              pee_pkg::CH_MUL: res = lhs * rhs;
              pee_pkg::CH_DIV: begin
                if (rhs == '0) begin
                  err = pee_pkg::ST_DIVZERO;
                end else begin
                  mag_l = lhs[31] ? -lhs : lhs;
                  mag_r = rhs[31] ? -rhs : rhs;
                  quo = mag_l / mag_r;
                  res = (lhs[31] ^ rhs[31]) ? -quo : quo;
                end
              end
              default: err = pee_pkg::ST_BADOP;
            endcase
            if (err == pee_pkg::ST_OK) begin
              operands[depth] = res;
              depth++;
            end
          end
        end
      end
      if (beat.last) begin
        if (err != pee_pkg::ST_OK) begin
          r.value = '0;
          r.status = err;
        end else if (depth != 1) begin
          r.value = '0;
          r.status = pee_pkg::ST_BADDEPTH;
        end else begin
          r.value = operands[0];
          r.status = pee_pkg::ST_OK;
        end
        expected_q.push_back(r);
        depth = 0;
        err = pee_pkg::ST_OK;
      end
    endfunction

    function void check_result(pee_pkg::out_t got);
      pee_pkg::out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: value %0d status %0d", got.value, got.status);
        errors++;
      end else begin
        want = expected_q.pop_front();
        checked++;
        status_seen[want.status]++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, got.value);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pee_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pee_pkg::out_t out_data;

  expr_scoreboard sb = new();
  logic [7:0] expr_chars[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int beats_sent = 0;
  int exprs_sent = 0;
  int quiet_cycles = 0;

  prefix_expression_evaluator #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_expr();
    pee_pkg::in_t beat;
    foreach (expr_chars[i]) begin
      beat.ch = expr_chars[i];
      beat.last = (i == expr_chars.size() - 1);
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= beat;
      do @(posedge clk); while (in_stall);
      sb.note_input(beat);
      beats_sent++;
    end
    exprs_sent++;
  endtask

  task automatic send_text(string s);
    expr_chars.delete();
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
    send_expr();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Build a well-formed expression in feed order: operands first, operator pops two.
  function automatic void gen_expr(int unsigned n_ops);
    int unsigned digits_left, ops_left, d;
    digits_left = n_ops + 1;
    ops_left = n_ops;
    d = 0;
    expr_chars.delete();
    while (digits_left + ops_left > 0) begin
      if ($urandom_range(0, 9) == 0) expr_chars.push_back(pee_pkg::CH_SPACE);
      if (d >= 2 && ops_left > 0 && (digits_left == 0 || $urandom_range(0, 1) == 1)) begin
        expr_chars.push_back(OP_CHARS[$urandom_range(0, 3)]);
        ops_left--;
        d--;
      end else begin
        expr_chars.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        digits_left--;
        d++;
      end
    end
  endfunction

  initial begin
    int kind, n, pos;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("9 0-");
    send_text("27*");
    send_text("27/");
    send_text("03/");
    send_text("+");
    send_text("1a");
    send_text("12a");
    send_text("12");
    send_text(" ");
    send_text("+5");
    expr_chars = '{8'h00};
    send_expr();
    expr_chars = '{pee_pkg::CH_ZERO + 8'd1, pee_pkg::CH_ZERO + 8'd2, 8'hFF};
    send_expr();
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 76 : (ph == 3) ? 37 : 0;
      stall_pct = (ph == 2) ? 76 : (ph == 3) ? 37 : 0;
      if (ph == 0) hold_seq++;
      while (beats_sent < 28 + (ph + 1) * PHASE_BEATS) begin
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 7);
          gen_expr(n);
        end else if (kind < 82) begin
          expr_chars.delete();
          repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 92) begin
          gen_expr($urandom_range(1, 6));
          case ($urandom_range(0, 3))
            0: begin
              pos = $urandom_range(0, expr_chars.size() - 1);
              expr_chars[pos] = 8'($urandom_range(0, 255));
            end
            1: expr_chars.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            2: expr_chars.push_back(OP_CHARS[$urandom_range(0, 3)]);
            default: void'(expr_chars.pop_back());
          endcase
        end else if (kind < 96) begin
          // most negative value on top of minus one
          expr_chars = '{pee_pkg::CH_ZERO + 8'd1, pee_pkg::CH_ZERO, pee_pkg::CH_SUB,
                         pee_pkg::CH_ZERO + 8'd2};
          repeat (10) begin
            expr_chars.push_back(pee_pkg::CH_ZERO + 8'd8);
            expr_chars.push_back(pee_pkg::CH_MUL);
          end
          expr_chars.push_back(OP_CHARS[$urandom_range(0, 3)]);
        end else if (kind < 98) begin
          expr_chars.delete();
          repeat (DEPTH) expr_chars.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          repeat (DEPTH - 1) expr_chars.push_back(OP_CHARS[$urandom_range(0, 1)]);
        end else begin
          expr_chars.delete();
          repeat (DEPTH + $urandom_range(1, 3)) begin
            expr_chars.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          end
          expr_chars.push_back(OP_CHARS[$urandom_range(0, 3)]);
        end
        send_expr();
      end
      drain_results();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) $error("%0d results never arrived", sb.expected_q.size());
    $display("fed %0d characters in %0d expressions, checked %0d results",
             beats_sent, exprs_sent, sb.checked);
    $display("status mix: ok %0d, overflow %0d, underflow %0d, div0 %0d, bad op %0d, depth %0d",
             sb.status_seen[pee_pkg::ST_OK], sb.status_seen[pee_pkg::ST_OVERFLOW],
             sb.status_seen[pee_pkg::ST_UNDERFLOW], sb.status_seen[pee_pkg::ST_DIVZERO],
             sb.status_seen[pee_pkg::ST_BADOP], sb.status_seen[pee_pkg::ST_BADDEPTH]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/pee_pkg.sv
rtl/pee_div.sv
rtl/pee_ctrl.sv
rtl/pee_dp.sv
rtl/prefix_expression_evaluator.sv
tb/tb_prefix_expression_evaluator.sv
